### rtl/contiguous_unit_allocator_unit_defines.svh
// Assertion macros shared by the allocator checker.
// Depends on nothing; included by bare file name.
`ifndef CONTIGUOUS_UNIT_ALLOCATOR_UNIT_DEFINES_SVH
`define CONTIGUOUS_UNIT_ALLOCATOR_UNIT_DEFINES_SVH

// Clocked assertion with an active-low reset that disables it.
`define CUA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assertion that a condition never holds.
`define CUA_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `CUA_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

### rtl/cua_pkg.sv
// Package of the contiguous unit allocator: codes, constants and types.
// Depends on nothing; used by the top level, the hole scanner and the checkers.
package cua_pkg;

  // Default number of managed units.
  localparam int unsigned MemUnitsDefault = 2048;

  // Units held in one word of the unit map.
  localparam int unsigned WordBits = 8;
  localparam int unsigned LogWordBits = 3;

  // Operation codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_WAIT       = 2'd1;
  localparam logic [1:0] ST_IMPOSSIBLE = 2'd2;

  // Register index of strategy_mode.
  localparam logic REG_STRATEGY = 1'b0;

  // Control that steers the hole scanner.
  typedef struct packed {
    logic clr;
    logic vld;
    logic last;
  } scan_ctl_t;

endpackage

### rtl/cua_if.sv
// Request and response channel interfaces of the allocator.
// Depends on nothing; the top level takes both as ports.
interface cua_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [12:0] block_size;
  logic [10:0] free_base;
  modport source (output valid, func, block_size, free_base, input ready);
  modport sink   (input valid, func, block_size, free_base, output ready);
endinterface

interface cua_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [10:0] placed_base;
  logic [11:0] units_free;
  modport source (output valid, status, placed_base, units_free, input ready);
  modport sink   (input valid, status, placed_base, units_free, output ready);
endinterface

### rtl/contiguous_unit_allocator_unit.sv
// Contiguous unit allocator: a bitmap of units in RAM, eight units a word.
// An allocate in placement mode that passes the size and free-count checks
// scans the whole map (one word a cycle), then marks the chosen hole with a
// read and a write per word touched. A free reads and writes each word it covers;
// other requests skip the map. One request is in flight at a time. After reset
// a clearing pass writes every map word before the first request is taken.
module contiguous_unit_allocator_unit #(
  parameter int unsigned MEM_UNITS = cua_pkg::MemUnitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cua_req_if.sink     req,
  cua_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned W     = cua_pkg::WordBits;
  localparam int unsigned LW    = cua_pkg::LogWordBits;
  localparam int unsigned AW    = $clog2(MEM_UNITS);
  localparam int unsigned CW    = $clog2(MEM_UNITS + 1);
  localparam int unsigned DEPTH = MEM_UNITS / W;
  localparam int unsigned DW    = AW - LW;
  localparam int unsigned EW    = (AW + 1 > 14) ? AW + 1 : 14;
  localparam logic [DW-1:0] LastWord = DW'(DEPTH - 1);
  localparam logic [EW-1:0] MemEnd   = EW'(MEM_UNITS);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SWT  = 3'd3;
  localparam logic [2:0] S_PICK = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_WR   = 3'd6;
  localparam logic [2:0] S_RESP = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [DW-1:0] addr_q, addr_d, end_q, end_d;
  logic [EW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic          mark_q, mark_d;
  logic [12:0]   size_q, size_d;
  logic [1:0]    stat_q, stat_d;
  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] count_q, count_d;
  logic          mode_q;
  logic          pend_q, pend_d, plast_q, plast_d;
  logic [DW-1:0] pidx_q, pidx_d;
  logic          ovld_q, ovld_d;
  logic [1:0]    ost_q, ost_d;
  logic [10:0]   obase_q, obase_d;
  logic [11:0]   ofree_q, ofree_d;

  logic          ram_we;
  logic [DW-1:0] ram_addr;
  logic [W-1:0]  ram_wdata, ram_rdata, mask, sel;
  logic [3:0]    pop;
  logic          scan_found, accept;
  logic [AW-1:0] scan_base;
  logic [EW-1:0] size_x, fbase_x, sum, hi_f, hi_m1, best_x, best_m1;
  logic [AW+10:0] base_wide;
  logic [CW+11:0] free_wide;
  cua_pkg::scan_ctl_t sctl;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = {31'b0, mode_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == cua_pkg::REG_STRATEGY) begin
      mode_q <= pwdata[0];
    end
  end

  assign accept    = req.valid && req.ready;
  assign req.ready = (state_q == S_IDLE);

  // Free range bounds of the incoming request.
  assign size_x  = EW'(req.block_size);
  assign fbase_x = EW'(req.free_base);
  assign sum     = fbase_x + size_x;
  assign hi_f    = (sum > MemEnd) ? MemEnd : sum;
  assign hi_m1   = hi_f - 1'b1;
  assign best_x  = EW'(scan_base) + EW'(size_q);
  assign best_m1 = best_x - 1'b1;

  // Mask of the units of word addr_q inside [lo, hi).
  always_comb begin
    for (int b = 0; b < W; b++) begin
      mask[b] = (EW'({addr_q, LW'(b)}) >= lo_q) && (EW'({addr_q, LW'(b)}) < hi_q);
    end
    sel = ram_rdata & mask;
    pop = '0;
    for (int b = 0; b < W; b++) begin
      pop = pop + 4'(sel[b]);
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    end_d   = end_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mark_d  = mark_q;
    size_d  = size_q;
    stat_d  = stat_q;
    base_d  = base_q;
    count_d = count_q;
    pend_d  = 1'b0;
    plast_d = 1'b0;
    pidx_d  = addr_q;
    ovld_d  = ovld_q && !rsp.ready;
    ost_d   = ost_q;
    obase_d = obase_q;
    ofree_d = ofree_q;
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = '0;
    sctl.clr  = accept;
    sctl.vld  = pend_q;
    sctl.last = plast_q;
    base_wide = {11'b0, base_q};
    free_wide = {12'b0, count_q};
    unique case (state_q)
      S_CLR: begin
        ram_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == LastWord) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          size_d  = req.block_size;
          stat_d  = cua_pkg::ST_DONE;
          base_d  = '0;
          state_d = S_RESP;
          if (req.func == cua_pkg::FUNC_FREE) begin
            if (req.block_size != '0 && fbase_x < MemEnd) begin
              lo_d    = fbase_x;
              hi_d    = hi_f;
              addr_d  = fbase_x[AW-1:LW];
              end_d   = hi_m1[AW-1:LW];
              mark_d  = 1'b0;
              state_d = S_RD;
            end
          end else if (!mode_q || req.block_size == '0) begin
            stat_d = cua_pkg::ST_DONE;
          end else if (size_x > MemEnd) begin
            stat_d = cua_pkg::ST_IMPOSSIBLE;
          end else if (size_x > EW'(count_q)) begin
            stat_d = cua_pkg::ST_WAIT;
          end else begin
            addr_d  = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        pend_d = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == LastWord) begin
          plast_d = 1'b1;
          state_d = S_SWT;
        end
      end
      S_SWT: begin
        state_d = S_PICK;
      end
      S_PICK: begin
        if (scan_found) begin
          lo_d    = EW'(scan_base);
          hi_d    = best_x;
          addr_d  = scan_base[AW-1:LW];
          end_d   = best_m1[AW-1:LW];
          mark_d  = 1'b1;
          base_d  = scan_base;
          count_d = count_q - CW'(size_q);
          state_d = S_RD;
        end else begin
          stat_d  = cua_pkg::ST_WAIT;
          state_d = S_RESP;
        end
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_wdata = mark_q ? (ram_rdata | mask) : (ram_rdata & ~mask);
        if (!mark_q) begin
          count_d = count_q + CW'(pop);
        end
        addr_d  = addr_q + 1'b1;
        state_d = (addr_q == end_q) ? S_RESP : S_RD;
      end
      S_RESP: begin
        if (!ovld_q || rsp.ready) begin
          ovld_d  = 1'b1;
          ost_d   = stat_q;
          obase_d = base_wide[10:0];
          ofree_d = free_wide[11:0];
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      addr_q  <= '0;
      count_q <= CW'(MEM_UNITS);
      pend_q  <= 1'b0;
      plast_q <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      plast_q <= plast_d;
      ovld_q  <= ovld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    end_q   <= end_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mark_q  <= mark_d;
    size_q  <= size_d;
    stat_q  <= stat_d;
    base_q  <= base_d;
    pidx_q  <= pidx_d;
    ost_q   <= ost_d;
    obase_q <= obase_d;
    ofree_q <= ofree_d;
  end

  assign rsp.valid       = ovld_q;
  assign rsp.status      = ost_q;
  assign rsp.placed_base = obase_q;
  assign rsp.units_free  = ofree_q;

  cua_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_map (
    .clk_i  (clk_i),
    .addr_i (ram_addr),
    .we_i   (ram_we),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  cua_hole_scan #(.MEM_UNITS(MEM_UNITS)) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sctl),
    .word_i (ram_rdata),
    .idx_i  (pidx_q),
    .len_i  (CW'(size_q)),
    .found_o(scan_found),
    .base_o (scan_base)
  );

endmodule

### rtl/cua_ram.sv
// Generic single-port RAM with a registered read.
// Depends on nothing.
module cua_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write, or read with the data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

### rtl/cua_hole_scan.sv
// Hole scanner: walks map words in order and keeps the best fitting free run.
// Depends on cua_pkg.
module cua_hole_scan #(
  parameter int unsigned MEM_UNITS = cua_pkg::MemUnitsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cua_pkg::scan_ctl_t                    ctl_i,
  input  logic [cua_pkg::WordBits-1:0]          word_i,
  input  logic [$clog2(MEM_UNITS)-cua_pkg::LogWordBits-1:0] idx_i,
  input  logic [$clog2(MEM_UNITS+1)-1:0]        len_i,
  output logic                                  found_o,
  output logic [$clog2(MEM_UNITS)-1:0]          base_o
);

  localparam int unsigned AW = $clog2(MEM_UNITS);
  localparam int unsigned CW = $clog2(MEM_UNITS + 1);
  localparam int unsigned LW = cua_pkg::LogWordBits;

  logic [CW-1:0] run_q, run_d, best_len_q, best_len_d;
  logic [AW-1:0] start_q, start_d, best_base_q, best_base_d;
  logic          found_q, found_d;

  // One word of the map: extend or close runs bit by bit.
  always_comb begin
    run_d       = run_q;
    start_d     = start_q;
    found_d     = found_q;
    best_len_d  = best_len_q;
    best_base_d = best_base_q;
    if (ctl_i.vld) begin
      for (int b = 0; b < cua_pkg::WordBits; b++) begin
        if (!word_i[b]) begin
          if (run_d == '0) begin
            start_d = {idx_i, LW'(b)};
          end
          run_d = run_d + 1'b1;
        end else begin
          if (run_d >= len_i && (!found_d || run_d < best_len_d)) begin
            found_d     = 1'b1;
            best_len_d  = run_d;
            best_base_d = start_d;
          end
          run_d = '0;
        end
      end
      if (ctl_i.last) begin
        if (run_d >= len_i && (!found_d || run_d < best_len_d)) begin
          found_d     = 1'b1;
          best_len_d  = run_d;
          best_base_d = start_d;
        end
      end
    end
    if (ctl_i.clr) begin
      run_d   = '0;
      found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      start_q     <= '0;
      found_q     <= 1'b0;
      best_len_q  <= '0;
      best_base_q <= '0;
    end else begin
      run_q       <= run_d;
      start_q     <= start_d;
      found_q     <= found_d;
      best_len_q  <= best_len_d;
      best_base_q <= best_base_d;
    end
  end

  assign found_o = found_q;
  assign base_o  = best_base_q;

endmodule

### rtl/cua_checker.sv
// Port-level checker of the allocator, bound to the top level.
// Depends on cua_pkg and the assertion macro header.
`include "contiguous_unit_allocator_unit_defines.svh"

module cua_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic [10:0] rsp_placed_base,
  input logic        pready
);

  // A response never carries an unused status code.
  `CUA_ASSERT_NEVER(a_status_code, clk_i, rst_ni, rsp_valid && rsp_status != cua_pkg::ST_DONE && rsp_status != cua_pkg::ST_WAIT && rsp_status != cua_pkg::ST_IMPOSSIBLE, "unused status code")

  // A refused request reports base zero.
  `CUA_ASSERT(a_base_zero, clk_i, rst_ni, rsp_valid && rsp_status != cua_pkg::ST_DONE |-> rsp_placed_base == 11'd0, "nonzero base on refusal")

  // A stalled response keeps its status.
  `CUA_ASSERT(a_hold, clk_i, rst_ni, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status), "stalled response changed")

  // The configuration port never stalls.
  `CUA_ASSERT(a_pready, clk_i, rst_ni, pready, "pready low")

endmodule

bind contiguous_unit_allocator_unit cua_checker u_cua_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_placed_base(rsp.placed_base),
  .pready         (pready)
);

### bench/tb_checker.sv
// Checker for the contiguous unit allocator: tracks the unit map and mode,
// predicts each response and compares it. Depends on cua_pkg and cua_if.
`timescale 1ns / 1ps

module tb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cua_req_if          req,
  cua_rsp_if          rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int unsigned fails_o,
  output int unsigned pending_o
);

  localparam int unsigned Units = cua_pkg::MemUnitsDefault;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] placed_base;
    logic [11:0] units_free;
  } alloc_rsp_t;

  logic        unit_used [Units];
  logic [11:0] free_count;
  logic        placement_mode;
  alloc_rsp_t  expected_rsps [$];

  // Smallest free run that holds len units, lowest address on a tie.
  function automatic logic find_tightest_hole(input int unsigned len,
                                              output int unsigned base);
    int unsigned pos, start, run, best_len;
    logic found;
    pos = 0;
    found = 1'b0;
    base = 0;
    best_len = 0;
    while (pos < Units) begin
      if (unit_used[pos]) begin
        pos++;
      end else begin
        start = pos;
        while (pos < Units && !unit_used[pos]) pos++;
        run = pos - start;
        if (run >= len && (!found || run < best_len)) begin
          found = 1'b1;
          base = start;
          best_len = run;
        end
      end
    end
    return found;
  endfunction

  // Applies one request to the tracked state and returns the response due.
  function automatic alloc_rsp_t apply_request(input logic func,
                                               input logic [12:0] size,
                                               input logic [10:0] fbase);
    alloc_rsp_t r;
    int unsigned base;
    r = '0;
    r.status = cua_pkg::ST_DONE;
    if (func == cua_pkg::FUNC_FREE) begin
      for (int unsigned i = 0; i < size; i++) begin
        if (fbase + i >= Units) break;
        if (unit_used[fbase + i]) begin
          unit_used[fbase + i] = 1'b0;
          free_count++;
        end
      end
    end else if (!placement_mode || size == 0) begin
      r.status = cua_pkg::ST_DONE;
    end else if (size > Units) begin
      r.status = cua_pkg::ST_IMPOSSIBLE;
    end else if (size > free_count) begin
      r.status = cua_pkg::ST_WAIT;
    end else if (find_tightest_hole(size, base)) begin
      for (int unsigned i = 0; i < size; i++) unit_used[base + i] = 1'b1;
      free_count = free_count - 12'(size);
      r.placed_base = base[10:0];
    end else begin
      r.status = cua_pkg::ST_WAIT;
    end
    r.units_free = free_count;
    return r;
  endfunction

  assign pending_o = expected_rsps.size();

  // Observe requests, register writes and responses at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Units; i++) unit_used[i] = 1'b0;
      free_count = 12'(Units);
      placement_mode = 1'b1;
      expected_rsps.delete();
      fails_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == cua_pkg::REG_STRATEGY) begin
        placement_mode = pwdata[0];
      end
      if (req.valid && req.ready) begin
        expected_rsps.push_back(apply_request(req.func, req.block_size, req.free_base));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response: status %0d base %0d free %0d",
                 rsp.status, rsp.placed_base, rsp.units_free);
          fails_o <= fails_o + 1;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status ||
              rsp.placed_base !== want.placed_base ||
              rsp.units_free !== want.units_free) begin
            fails_o <= fails_o + 1;
          end
          if (rsp.status !== want.status)
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
          if (rsp.placed_base !== want.placed_base)
            $error("placed_base: expected %0d, actual %0d",
                   want.placed_base, rsp.placed_base);
          if (rsp.units_free !== want.units_free)
            $error("units_free: expected %0d, actual %0d",
                   want.units_free, rsp.units_free);
        end
      end
    end
  end

endmodule

### bench/tb_top.sv
// Top of the allocator testbench: clock, reset, request stimulus, register
// writes and verdict. Depends on cua_pkg, cua_if, tb_checker and the block.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned Units      = cua_pkg::MemUnitsDefault;
  localparam int unsigned CycleLimit = 2500000;

  typedef struct packed {
    logic [10:0] base;
    logic [12:0] size;
  } live_block_t;

  typedef struct packed {
    logic        func;
    logic [12:0] size;
    logic        mode;
  } sent_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int unsigned fails, pending;
  int unsigned cycles = 0;
  logic        no_idle = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  logic        cur_mode = 1'b1;
  live_block_t live_blocks [$];
  sent_req_t   sent_reqs [$];

  cua_req_if req ();
  cua_rsp_if rsp ();

  contiguous_unit_allocator_unit dut (
    .clk_i, .rst_ni, .req(req.sink), .rsp(rsp.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tb_checker u_checker (
    .clk_i, .rst_ni, .req, .rsp, .psel, .penable, .pwrite, .pready,
    .paddr, .pwdata, .fails_o(fails), .pending_o(pending)
  );

  always #1 clk_i = ~clk_i;

  // Give up on a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Note which allocations landed, so that frees can target live blocks.
  always @(posedge clk_i) begin
    sent_req_t s;
    if (rst_ni) begin
      if (req.valid && req.ready) sent_reqs.push_back({req.func, req.block_size, cur_mode});
      if (rsp.valid && rsp.ready && sent_reqs.size() > 0) begin
        s = sent_reqs.pop_front();
        if (s.func == cua_pkg::FUNC_ALLOC && s.mode && rsp.status == cua_pkg::ST_DONE &&
            s.size != 0 && s.size <= Units)
          live_blocks.push_back({rsp.placed_base, s.size});
      end
    end
  end

  // Response side: random stall bursts, one long hold-off, none at the end.
  initial begin
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_done = 1'b1;
        rsp.ready <= 1'b1;
      end else if (!no_idle && $urandom_range(7) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(10, 1)) @(posedge clk_i);
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Offer one request and wait until it is taken.
  task automatic send_request(input logic func, input logic [12:0] size,
                              input logic [10:0] fbase);
    if (!no_idle && !(hold_go && !hold_done) && $urandom_range(5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.func       <= func;
    req.block_size <= size;
    req.free_base  <= fbase;
    do @(posedge clk_i); while (!(req.valid && req.ready));
  endtask

  // One random request: mostly allocations and frees of live blocks.
  task automatic send_random_request();
    int unsigned pick, idx;
    logic [12:0] size;
    live_block_t blk;
    pick = $urandom_range(99);
    if (pick < 50) begin
      pick = $urandom_range(99);
      if (pick < 70) size = 13'($urandom_range(32, 1));
      else if (pick < 90) size = 13'($urandom_range(300, 33));
      else if (pick < 97) size = 13'($urandom_range(Units, 301));
      else size = 13'($urandom_range(8191, Units + 1));
      send_request(cua_pkg::FUNC_ALLOC, size, 11'($urandom));
    end else if (pick < 88 && live_blocks.size() > 0) begin
      idx = $urandom_range(live_blocks.size() - 1);
      blk = live_blocks[idx];
      live_blocks.delete(idx);
      if ($urandom_range(9) == 0) blk.size = blk.size + 13'($urandom_range(8));
      send_request(cua_pkg::FUNC_FREE, blk.size, blk.base);
    end else begin
      size = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(64));
      send_request(cua_pkg::FUNC_FREE, size, 11'($urandom));
    end
  endtask

  // Wait until every response is in, then a short settling gap.
  task automatic wait_idle();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_mode(input logic mode);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {cua_pkg::REG_STRATEGY, 2'b00};
    pwdata  <= {$urandom} & 32'hFFFF_FFFE | mode;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_mode = mode;
  endtask

  // Main sequence.
  initial begin
    req.valid = 1'b0;
    req.func = cua_pkg::FUNC_ALLOC;
    req.block_size = '0;
    req.free_base = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part in placement mode.
    write_mode(1'b1);
    send_request(cua_pkg::FUNC_ALLOC, 13'd0, 11'h7FF);
    send_request(cua_pkg::FUNC_ALLOC, 13'd1, 11'd0);
    send_request(cua_pkg::FUNC_ALLOC, 13'd2048, 11'd0);     // more than is free
    send_request(cua_pkg::FUNC_ALLOC, 13'd4096, 11'd0);     // beyond memory
    send_request(cua_pkg::FUNC_ALLOC, 13'h1FFF, 11'd0);
    send_request(cua_pkg::FUNC_FREE, 13'd1, 11'd0);
    send_request(cua_pkg::FUNC_ALLOC, 13'd2048, 11'd0);     // whole memory
    send_request(cua_pkg::FUNC_ALLOC, 13'd1, 11'd0);        // nothing left
    send_request(cua_pkg::FUNC_FREE, 13'd100, 11'd2040);    // runs past the end
    send_request(cua_pkg::FUNC_FREE, 13'd0, 11'd0);
    send_request(cua_pkg::FUNC_FREE, 13'h1FFF, 11'd0);      // all of it
    send_request(cua_pkg::FUNC_FREE, 13'd4, 11'd8);         // already free
    send_request(cua_pkg::FUNC_ALLOC, 13'd10, 11'd0);
    send_request(cua_pkg::FUNC_ALLOC, 13'd5, 11'd0);
    send_request(cua_pkg::FUNC_ALLOC, 13'd20, 11'd0);
    send_request(cua_pkg::FUNC_FREE, 13'd5, 11'd10);
    send_request(cua_pkg::FUNC_ALLOC, 13'd4, 11'd0);        // tightest hole wins
    send_request(cua_pkg::FUNC_FREE, 13'd10, 11'd0);
    send_request(cua_pkg::FUNC_ALLOC, 13'd1, 11'd0);
    send_request(cua_pkg::FUNC_ALLOC, 13'd2030, 11'd0);     // more than is free
    send_request(cua_pkg::FUNC_FREE, 13'h1FFF, 11'd0);
    wait_idle();

    // Random placement phase with the long response hold-off near its start.
    for (int i = 0; i < 150; i++) begin
      if (i == 20) hold_go = 1'b1;
      send_random_request();
    end
    wait_idle();

    // Infinite mode.
    write_mode(1'b0);
    send_request(cua_pkg::FUNC_ALLOC, 13'h1FFF, 11'h7FF);
    send_request(cua_pkg::FUNC_ALLOC, 13'd2048, 11'd0);
    for (int i = 0; i < 50; i++) send_random_request();
    wait_idle();

    // Placement again, the last stretch with no idling.
    write_mode(1'b1);
    for (int i = 0; i < 250; i++) begin
      if (i == 180) no_idle = 1'b1;
      send_random_request();
    end
    wait_idle();
    repeat (50) @(posedge clk_i);

    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### contiguous_unit_allocator_unit.f
+incdir+rtl
rtl/cua_pkg.sv
rtl/cua_if.sv
rtl/cua_ram.sv
rtl/cua_hole_scan.sv
rtl/contiguous_unit_allocator_unit.sv
rtl/cua_checker.sv
bench/tb_checker.sv
bench/tb_top.sv
